/* rtl/core/ar_pkg.sv */
package ar_pkg;

	localparam int DIM_BITS_DEF = 16;
	localparam int IN_W         = 16;
	localparam int OUT_W        = 16;

	localparam logic [OUT_W-1:0] RATIO_W_SHORT = OUT_W'(8);
	localparam logic [OUT_W-1:0] RATIO_H_SHORT = OUT_W'(5);
	localparam logic [OUT_W-1:0] RATIO_W_LONG  = OUT_W'(16);
	localparam logic [OUT_W-1:0] RATIO_H_LONG  = OUT_W'(10);

endpackage

/* rtl/core/ar_div.sv */
module ar_div
	import ar_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIM_BITS-1:0] dividend,
	input  logic [DIM_BITS-1:0] divisor,
	output logic                done,
	output logic [DIM_BITS-1:0] quotient,
	output logic [DIM_BITS-1:0] remainder
);

	localparam int CW = $clog2(DIM_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [DIM_BITS-1:0] rem_q;
	logic [DIM_BITS-1:0] quo_q;
	logic [DIM_BITS-1:0] div_q;

	logic [DIM_BITS:0]   shifted;
	logic [DIM_BITS:0]   diff;
	logic                fits;
	logic [DIM_BITS-1:0] rem_next;

	assign shifted  = {rem_q, quo_q[DIM_BITS-1]};
	assign diff     = shifted - {1'b0, div_q};
	assign fits     = ~diff[DIM_BITS];
	assign rem_next = fits ? diff[DIM_BITS-1:0] : shifted[DIM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIM_BITS-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/core/aspect_ratio_reducer.sv */
// Euclid remainder steps find the GCD, then width and then height are divided by it; a zero
// dimension skips all division. One restoring divider, one quotient bit per cycle, does all
// the remainder and quotient work. Throughput: one item at a time, the next accepted after the
// result is registered. arst_n clears the sequencer and the output valid; no clearing pass.
module aspect_ratio_reducer
	import ar_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [IN_W-1:0]  width,
	input  logic [IN_W-1:0]  height,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OUT_W-1:0] ratio_w,
	output logic [OUT_W-1:0] ratio_h,
	output logic             zero_dim
);

	localparam int USE_W = (DIM_BITS < IN_W) ? DIM_BITS : IN_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_DIVW,
		S_DIVH,
		S_DONE
	} state_t;

	state_t              state_q;
	logic                start_q;
	logic                zero_q;
	logic                out_valid_q;
	logic [DIM_BITS-1:0] w_q;
	logic [DIM_BITS-1:0] h_q;
	logic [DIM_BITS-1:0] a_q;
	logic [DIM_BITS-1:0] b_q;
	logic [DIM_BITS-1:0] rw_q;
	logic [DIM_BITS-1:0] rh_q;
	logic [OUT_W-1:0]    ratio_w_q;
	logic [OUT_W-1:0]    ratio_h_q;
	logic                zero_dim_q;

	logic [DIM_BITS-1:0] w_in;
	logic [DIM_BITS-1:0] h_in;
	logic [DIM_BITS-1:0] dividend;
	logic                div_done;
	logic [DIM_BITS-1:0] quotient;
	logic [DIM_BITS-1:0] remainder;
	logic [OUT_W-1:0]    rw_out;
	logic [OUT_W-1:0]    rh_out;
	logic                accept;
	logic                load_out;
	logic                is_short;

	assign w_in   = DIM_BITS'(width[USE_W-1:0]);
	assign h_in   = DIM_BITS'(height[USE_W-1:0]);
	assign accept = in_valid && (state_q == S_IDLE);

	always_comb begin
		case (state_q)
			S_GCD:   dividend = a_q;
			S_DIVW:  dividend = w_q;
			default: dividend = h_q;
		endcase
	end

	ar_div #(
		.DIM_BITS(DIM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dividend),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (quotient),
		.remainder(remainder)
	);

	assign rw_out   = OUT_W'(rw_q);
	assign rh_out   = OUT_W'(rh_q);
	assign is_short = (rw_out == RATIO_W_SHORT) && (rh_out == RATIO_H_SHORT);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (w_in == '0 || h_in == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_GCD;
							start_q <= 1'b1;
						end
					end
				end
				S_GCD: begin
					if (div_done) begin
						start_q <= 1'b1;
						if (remainder == '0) begin
							state_q <= S_DIVW;
						end
					end
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_DIVH;
						start_q <= 1'b1;
					end
				end
				S_DIVH: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q    <= w_in;
			h_q    <= h_in;
			a_q    <= w_in;
			b_q    <= h_in;
			rw_q   <= '0;
			rh_q   <= '0;
			zero_q <= (w_in == '0) || (h_in == '0);
		end
		if (state_q == S_GCD && div_done && remainder != '0) begin
			a_q <= b_q;
			b_q <= remainder;
		end
		if (state_q == S_DIVW && div_done) begin
			rw_q <= quotient;
		end
		if (state_q == S_DIVH && div_done) begin
			rh_q <= quotient;
		end
		if (load_out) begin
			ratio_w_q  <= is_short ? RATIO_W_LONG : rw_out;
			ratio_h_q  <= is_short ? RATIO_H_LONG : rh_out;
			zero_dim_q <= zero_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign ratio_w   = ratio_w_q;
	assign ratio_h   = ratio_h_q;
	assign zero_dim  = zero_dim_q;

endmodule
